>>> rtl/ce64_pkg.sv
`timescale 1ns / 1ps
// Shared types, mask table and parity helpers for the 64-bit CSI-2 ECC checker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ce64_pkg;

  localparam int DataBits = 64;
  localparam int EccBits  = 8;
  localparam int QDepth   = 2;

  // Row r selects the data bits that feed ECC bit r.
  localparam logic [DataBits-1:0] MaskRows [EccBits] = '{
    64'h0422D5844BF12CB7,
    64'h0844EA8895F2555B,
    64'h1089F31126749A6D,
    64'h21117C2238B8E38E,
    64'h421EB043C0DF03F0,
    64'h83E0307C00EFFC00,
    64'hFC00C07FFF000000,
    64'hFFFF0F8000000000
  };

  typedef enum logic [1:0] {
    ST_GOOD          = 2'd0,
    ST_PARITY_ONLY   = 2'd1,
    ST_CORRECTED     = 2'd2,
    ST_UNCORRECTABLE = 2'd3
  } status_e;

  // One word with its computed ECC and syndrome, travelling from the front end to the back end.
  typedef struct packed {
    logic [DataBits-1:0] data;
    logic [EccBits-1:0]  ecc;
    logic [EccBits-1:0]  syn;
  } item_t;

  // Queue status seen by the front end (full) and the back end (not empty).
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [EccBits-1:0] ecc_of(input logic [DataBits-1:0] d);
    logic [EccBits-1:0] e;
    e = '0;
    for (int r = 0; r < EccBits; r++) begin
      e[r] = ^(d & MaskRows[r]);
    end
    return e;
  endfunction

  // Syndrome that a flip of data bit b produces.
  function automatic logic [EccBits-1:0] column_of(input int b);
    logic [EccBits-1:0] c;
    c = '0;
    for (int r = 0; r < EccBits; r++) begin
      c[r] = MaskRows[r][b];
    end
    return c;
  endfunction

endpackage

>>> rtl/csi2_ecc64_secded.sv
`timescale 1ns / 1ps
// Top level of the 64-bit CSI-2 SECDED ECC checker: front end, queue and back end.
// Depends on ce64_pkg, ce64_front, ce64_queue and ce64_back.

// A word (data_word_i with received_ecc_i) is taken at every rising edge where
// start_i is high and busy_o is low. Each word yields exactly one result, in
// order, shown for one cycle with result_valid_o high: computed_ecc_o is the
// ECC computed from the data, check_status_o is 0 for a clean word, 1 when only
// an ECC bit was hit, 2 when one data bit was found and flipped in fixed_data_o,
// and 3 when the error cannot be corrected and the data passes through as is.
// The block takes one word per cycle while busy_o is low. A word passes in order
// through the front end register that computes the ECC and syndrome, the
// two-entry queue, and the back end register that holds the syndrome match
// against the 64 data columns and drives the result strobe.
// The receiver cannot stall the result, so the back end drains the queue every
// cycle and busy_o stays low in operation; it is kept as the front end's
// back-pressure signal should the queue ever be full.
module csi2_ecc64_secded (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ce64_pkg::DataBits-1:0]   data_word_i,
  input  logic [ce64_pkg::EccBits-1:0]    received_ecc_i,
  output logic                            result_valid_o,
  output logic [ce64_pkg::EccBits-1:0]    computed_ecc_o,
  output logic [1:0]                      check_status_o,
  output logic [ce64_pkg::DataBits-1:0]   fixed_data_o
);

  logic               push, pop;
  ce64_pkg::item_t    front_item, queue_item;
  ce64_pkg::q_stat_t  q_stat;
  ce64_pkg::status_e  status;

  ce64_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .data_word_i    (data_word_i),
    .received_ecc_i (received_ecc_i),
    .q_stat_i       (q_stat),
    .busy_o         (busy_o),
    .push_o         (push),
    .item_o         (front_item)
  );

  ce64_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (q_stat)
  );

  ce64_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .item_i         (queue_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .computed_ecc_o (computed_ecc_o),
    .status_o       (status),
    .fixed_data_o   (fixed_data_o)
  );

  assign check_status_o = status;

  // The back end drains one word per cycle, so the queue can never fill.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("front end stalled although the back end never stalls");

endmodule

>>> rtl/ce64_front.sv
`timescale 1ns / 1ps
// Front end: takes a word, computes its ECC and syndrome, and holds it for the queue.
// Depends on ce64_pkg.
module ce64_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ce64_pkg::DataBits-1:0]       data_word_i,
  input  logic [ce64_pkg::EccBits-1:0]        received_ecc_i,
  input  ce64_pkg::q_stat_t                   q_stat_i,
  output logic                                busy_o,
  output logic                                push_o,
  output ce64_pkg::item_t                     item_o
);

  logic                          valid_q, valid_d;
  ce64_pkg::item_t               item_q;
  logic                          take;
  logic [ce64_pkg::EccBits-1:0]  ecc_calc;

  assign push_o = valid_q && !q_stat_i.full;
  assign busy_o = valid_q && q_stat_i.full;
  assign take   = start_i && !busy_o;
  assign item_o = item_q;

  always_comb begin
    ecc_calc = ce64_pkg::ecc_of(data_word_i);
    valid_d  = take ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data <= data_word_i;
      item_q.ecc  <= ecc_calc;
      item_q.syn  <= ecc_calc ^ received_ecc_i;
    end
  end

endmodule

>>> rtl/ce64_queue.sv
`timescale 1ns / 1ps
// Two-entry queue that decouples the front end from the back end.
// Depends on ce64_pkg.
module ce64_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ce64_pkg::item_t   item_i,
  input  logic              pop_i,
  output ce64_pkg::item_t   item_o,
  output ce64_pkg::q_stat_t stat_o
);

  localparam int PtrW = $clog2(ce64_pkg::QDepth);
  localparam int CntW = $clog2(ce64_pkg::QDepth + 1);

  ce64_pkg::item_t  mem_q [ce64_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    stat_o.full  = (cnt_q == CntW'(ce64_pkg::QDepth));
    stat_o.empty = (cnt_q == '0);
    item_o       = mem_q[rd_ptr_q];
    wr_ptr_d     = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d     = pop_i  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d        = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ce64_pkg::QDepth))
    else $error("queue fill count out of range");

endmodule

>>> rtl/ce64_back.sv
`timescale 1ns / 1ps
// Back end: classifies the syndrome, locates and flips a single data bit, registers the result.
// Depends on ce64_pkg.
module ce64_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ce64_pkg::q_stat_t               q_stat_i,
  input  ce64_pkg::item_t                 item_i,
  output logic                            pop_o,
  output logic                            result_valid_o,
  output logic [ce64_pkg::EccBits-1:0]    computed_ecc_o,
  output ce64_pkg::status_e               status_o,
  output logic [ce64_pkg::DataBits-1:0]   fixed_data_o
);

  logic                           valid_q;
  logic [ce64_pkg::EccBits-1:0]   ecc_q;
  ce64_pkg::status_e              status_q, status_d;
  logic [ce64_pkg::DataBits-1:0]  data_q, data_d;
  logic [ce64_pkg::DataBits-1:0]  match, pick;

  // The receiver never stalls, so anything queued goes out at once.
  assign pop_o = !q_stat_i.empty;

  always_comb begin
    for (int b = 0; b < ce64_pkg::DataBits; b++) begin
      match[b] = (item_i.syn == ce64_pkg::column_of(b));
    end
    // Lowest matching column wins.
    pick   = match & (~match + ce64_pkg::DataBits'(1));
    data_d = item_i.data;
    priority if (item_i.syn == '0) begin
      status_d = ce64_pkg::ST_GOOD;
    end else if ($onehot(item_i.syn)) begin
      status_d = ce64_pkg::ST_PARITY_ONLY;
    end else if (|match) begin
      status_d = ce64_pkg::ST_CORRECTED;
      data_d   = item_i.data ^ pick;
    end else begin
      status_d = ce64_pkg::ST_UNCORRECTABLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ecc_q    <= item_i.ecc;
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign result_valid_o = valid_q;
  assign computed_ecc_o = ecc_q;
  assign status_o       = status_q;
  assign fixed_data_o   = data_q;

endmodule
